// ===== rtl/srpq_pkg.sv =====
// Package for the sorted ring priority queue: sizes, codes, payload and link types.
package srpq_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int KEY_WIDTH = 32;

    localparam int NUM_CELLS   = MAX_DEPTH - 1;
    localparam int CNT_W       = $clog2(MAX_DEPTH);
    localparam int CAP_W       = 7;
    localparam int CNT_OUT_W   = 6;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_PEEK_ALT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    typedef struct packed {
        action_t                     action;
        logic signed [KEY_WIDTH-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_t                     status;
        logic signed [KEY_WIDTH-1:0] head_value;
        logic [CNT_OUT_W-1:0]        element_count;
    } out_item_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic                        ins;
        logic                        rem;
        logic                        clr;
        logic signed [KEY_WIDTH-1:0] key;
    } cell_ctrl_t;

    // What a cell shows its neighbours.
    typedef struct packed {
        logic                        valid;
        logic                        gt;
        logic signed [KEY_WIDTH-1:0] key;
    } cell_link_t;

endpackage

// ===== rtl/srpq_cell.sv =====
// One cell of the sorted chain: holds one key and shifts with its neighbours.
module srpq_cell
    import srpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t prev,
    input  cell_link_t next,
    output cell_link_t link
);

    logic                        valid_reg;
    logic                        valid_next;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;
    logic                        gt;

    // Strictly greater keys move aside, so equal keys keep arrival order.
    assign gt = valid_reg && ($signed(key_reg) > $signed(ctrl.key));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.rem)
        begin
            valid_next = next.valid;
            key_next   = next.key;
        end
        else if (ctrl.ins)
        begin
            if (prev.gt)
            begin
                valid_next = prev.valid;
                key_next   = prev.key;
            end
            else if (prev.valid && (!valid_reg || gt))
            begin
                valid_next = 1'b1;
                key_next   = ctrl.key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.key   = key_reg;

endmodule

// ===== rtl/srpq_out_buf.sv =====
// Two-entry result buffer: output register plus skid stage.
module srpq_out_buf
    import srpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      busy,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t skid_data_reg;
    out_item_t skid_data_next;
    logic      take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign busy      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/sorted_ring_priority_queue.sv =====
// Top level of the sorted ring priority queue: cell chain, control and result buffer.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one transaction per
//   operation: insert a nonzero signed key, delete the head, or peek the head.
//   Action code 3 acts as a peek. A transaction is taken on a rising edge with
//   in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   result per operation: status, head key (zero unless status is ok) and the
//   element count after the operation.
//   The result of an accepted transaction is registered in the output register
//   (or the skid stage). One transaction is taken per cycle while in_stall is
//   low: all cells compare against the broadcast key and shift at the same edge.
//   When the receiver stalls, the output register holds its result and a skid
//   stage takes one more; in_stall rises only while the skid stage is full.
//   cfg_we / cfg_data write the ring size in use (clamped to 2..MAX_DEPTH); the
//   queue then holds at most that size minus one keys, and the write empties it.
//   Reset empties the queue, sets the ring size to MAX_DEPTH and drops any
//   pending result.
module sorted_ring_priority_queue
    import srpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] limit_next;

    logic             accept;
    logic             is_insert;
    logic             is_delete;
    logic             key_zero;
    logic             full;
    logic             empty;
    logic             do_ins;
    logic             do_rem;
    logic [31:0]      cfg_ext;
    cell_ctrl_t       ctrl;
    out_item_t        result;
    cell_link_t       links [NUM_CELLS];
    logic [NUM_CELLS-1:0] valid_vec;

    localparam cell_link_t HEAD_LINK = '{valid: 1'b1, gt: 1'b0, key: '0};
    localparam cell_link_t TAIL_LINK = '{valid: 1'b0, gt: 1'b0, key: '0};

    assign accept    = in_valid && !in_stall;
    assign is_insert = (in_data.action == ACT_INSERT);
    assign is_delete = (in_data.action == ACT_DELETE);
    assign key_zero  = (in_data.value == '0);
    assign full      = (count_reg >= limit_reg);
    assign empty     = (count_reg == '0);
    assign do_ins    = accept && is_insert && !key_zero && !full;
    assign do_rem    = accept && is_delete && !empty;

    // Broadcast the operation to every cell; a register write clears them all.
    assign ctrl.ins = do_ins;
    assign ctrl.rem = do_rem;
    assign ctrl.clr = cfg_we;
    assign ctrl.key = in_data.value;

    // Chain of cells, head at index zero.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            cell_link_t prev_link;
            cell_link_t next_link;
            if (gi == 0)
            begin : g_first
                assign prev_link = HEAD_LINK;
            end
            else
            begin : g_mid_prev
                assign prev_link = links[gi-1];
            end
            if (gi == NUM_CELLS - 1)
            begin : g_last
                assign next_link = TAIL_LINK;
            end
            else
            begin : g_mid_next
                assign next_link = links[gi+1];
            end
            srpq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .prev  (prev_link),
                .next  (next_link),
                .link  (links[gi])
            );
            assign valid_vec[gi] = links[gi].valid;
        end
    endgenerate

    // Clamp the written ring size and hold it as the entry limit (size minus one).
    assign cfg_ext = 32'(cfg_data);

    always_comb
    begin
        limit_next = limit_reg;
        count_next = count_reg;
        if (cfg_we)
        begin
            count_next = '0;
            if (cfg_ext < 32'd2)
            begin
                limit_next = CNT_W'(1);
            end
            else if (cfg_ext > 32'(MAX_DEPTH))
            begin
                limit_next = CNT_W'(MAX_DEPTH - 1);
            end
            else
            begin
                limit_next = CNT_W'(cfg_ext - 32'd1);
            end
        end
        else if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= CNT_W'(MAX_DEPTH - 1);
        end
        else
        begin
            count_reg <= count_next;
            limit_reg <= limit_next;
        end
    end

    // Build the result; the zero test comes before the full test.
    always_comb
    begin
        result.head_value = '0;
        if (is_insert)
        begin
            if (key_zero)
            begin
                result.status = ST_ZERO;
            end
            else if (full)
            begin
                result.status = ST_FULL;
            end
            else
            begin
                result.status = ST_OK;
            end
        end
        else if (empty)
        begin
            result.status = ST_EMPTY;
        end
        else
        begin
            result.status     = ST_OK;
            result.head_value = links[0].key;
        end
        result.element_count = CNT_OUT_W'(count_next);
    end

    srpq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .busy      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // The count tracks the occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("element count differs from occupied cells");

    // Occupied cells form an unbroken run from the head.
    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + NUM_CELLS'(1))) == '0)
        else $error("gap in the cell chain");

    // The skid stage is only ever filled behind a waiting output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid stage holds a result with the output register empty");

    // A successful delete shortens the queue by one.
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_rem && !cfg_we |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not decrement the count");
`endif

endmodule
